// ===== rtl/rational_arith_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared same-cycle and next-cycle implication checks on clk, gated by rst.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_arith_unit check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_arith_unit check failed");

`endif

// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, sequencer states and divider request/response types.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam int unsigned DivWidth = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_QN_WAIT,
    ST_QD_WAIT,
    ST_DONE
  } rau_state_t;

  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } rau_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DivWidth-1:0] quotient;
    logic [DivWidth-1:0] remainder;
  } rau_div_rsp_t;

endpackage

// ===== rtl/rau_divider.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// Euclidean remainder steps and the final reduction quotients.
// ----------------------------------------------------------------------------
module rau_divider (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::rau_div_req_t req,
  output rau_pkg::rau_div_rsp_t rsp
);

  localparam int unsigned CntWidth = $clog2(rau_pkg::DivWidth);

  logic                          busy;
  logic                          done;
  logic [CntWidth-1:0]           cnt;
  logic [rau_pkg::DivWidth-1:0]  quo;
  logic [rau_pkg::DivWidth-1:0]  rem;
  logic [rau_pkg::DivWidth:0]    shifted;
  logic [rau_pkg::DivWidth+1:0]  diff;
  logic                          ge;

  assign shifted = {rem, quo[rau_pkg::DivWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, req.divisor};
  assign ge      = ~diff[rau_pkg::DivWidth+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntWidth'(rau_pkg::DivWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[rau_pkg::DivWidth-2:0], ge};
      rem <= ge ? diff[rau_pkg::DivWidth-1:0] : shifted[rau_pkg::DivWidth-1:0];
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Sequence: multiply and divide pass through MUL0, MUL1, COMB and DONE.
// Add and subtract also pass MUL2, then GCD_CHK with one divider pass per Euclidean
// remainder step and two for the reduction quotients; 0/0 goes from GCD_CHK to DONE.
// Throughput: one request at a time; a new request is taken in idle while a
// finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply and divide with GCD reduction for add and
// subtract, built on one multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_defines.svh"

module rational_arith_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // a_numerator, a_denominator, b_numerator, b_denominator
  input  logic [1:0]  s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // result_numerator, result_denominator, zero pad
  output logic [0:0]  m_tuser   // gcd_error
);

  rau_pkg::rau_state_t   state;
  rau_pkg::rau_state_t   state_next;
  rau_pkg::rau_div_req_t div_req;
  rau_pkg::rau_div_rsp_t div_rsp;

  logic [1:0]         mode;
  logic signed [15:0] an;
  logic signed [15:0] ad;
  logic signed [15:0] bn;
  logic signed [15:0] bd;
  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [31:0] prod;
  logic signed [31:0] p0;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [32:0] sum;
  logic signed [32:0] num;
  logic signed [31:0] den;
  logic               err;
  logic [31:0]        gx;
  logic [31:0]        gy;
  logic [31:0]        qn;
  logic [31:0]        num_mag;
  logic [31:0]        den_mag;
  logic [31:0]        sum_mag;
  logic [32:0]        sum_neg;
  logic [32:0]        num_neg;
  logic               out_free;
  logic               add_sub;

  assign add_sub  = (mode == rau_pkg::MODE_ADD) || (mode == rau_pkg::MODE_SUB);
  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = (state == rau_pkg::ST_IDLE);

  always_comb begin
    case (state)
      rau_pkg::ST_MUL0: begin
        mul_a = an;
        mul_b = (mode == rau_pkg::MODE_MUL) ? bn : bd;
      end
      rau_pkg::ST_MUL1: begin
        mul_a = ad;
        mul_b = (mode == rau_pkg::MODE_DIV) ? bn : bd;
      end
      rau_pkg::ST_MUL2: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign sum     = (mode == rau_pkg::MODE_SUB) ? ({p0[31], p0} - {p2[31], p2})
                                               : ({p0[31], p0} + {p2[31], p2});
  assign sum_neg = -sum;
  assign sum_mag = sum[32] ? sum_neg[31:0] : sum[31:0];
  assign num_neg = -num;
  assign num_mag = num[32] ? num_neg[31:0] : num[31:0];
  assign den_mag = den[31] ? 32'(-den) : 32'(den);

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = gx;
    div_req.divisor  = gy;
    case (state)
      rau_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = rau_pkg::ST_MUL0;
      end
      rau_pkg::ST_MUL0: state_next = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: state_next = add_sub ? rau_pkg::ST_MUL2 : rau_pkg::ST_COMB;
      rau_pkg::ST_MUL2: state_next = rau_pkg::ST_COMB;
      rau_pkg::ST_COMB: state_next = add_sub ? rau_pkg::ST_GCD_CHK : rau_pkg::ST_DONE;
      rau_pkg::ST_GCD_CHK: begin
        if (gy != '0) begin
          div_req.start = 1'b1;
          state_next    = rau_pkg::ST_GCD_WAIT;
        end else if (gx == '0) begin
          state_next = rau_pkg::ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num_mag;
          div_req.divisor  = gx;
          state_next       = rau_pkg::ST_QN_WAIT;
        end
      end
      rau_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) state_next = rau_pkg::ST_GCD_CHK;
      end
      rau_pkg::ST_QN_WAIT: begin
        div_req.dividend = den_mag;
        div_req.divisor  = gx;
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = rau_pkg::ST_QD_WAIT;
        end
      end
      rau_pkg::ST_QD_WAIT: begin
        div_req.divisor = gx;
        if (div_rsp.done) state_next = rau_pkg::ST_DONE;
      end
      rau_pkg::ST_DONE: begin
        if (out_free) state_next = rau_pkg::ST_IDLE;
      end
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  rau_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mode <= s_tuser;
          an   <= s_tdata[15:0];
          ad   <= s_tdata[31:16];
          bn   <= s_tdata[47:32];
          bd   <= s_tdata[63:48];
        end
      end
      rau_pkg::ST_MUL0: p0 <= prod;
      rau_pkg::ST_MUL1: p1 <= prod;
      rau_pkg::ST_MUL2: p2 <= prod;
      rau_pkg::ST_COMB: begin
        num <= add_sub ? sum : {p0[31], p0};
        den <= p1;
        err <= 1'b0;
        gx  <= sum_mag;
        gy  <= p1[31] ? 32'(-p1) : 32'(p1);
      end
      rau_pkg::ST_GCD_CHK: begin
        if (gy == '0 && gx == '0) err <= 1'b1;
      end
      rau_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          gx <= gy;
          gy <= div_rsp.remainder;
        end
      end
      rau_pkg::ST_QN_WAIT: begin
        if (div_rsp.done) qn <= div_rsp.quotient;
      end
      rau_pkg::ST_QD_WAIT: begin
        if (div_rsp.done) begin
          num <= num[32] ? -{1'b0, qn} : {1'b0, qn};
          den <= den[31] ? -div_rsp.quotient : div_rsp.quotient;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rau_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rau_pkg::ST_DONE && out_free) begin
      m_tdata <= {7'd0, den, num};
      m_tuser <= err;
    end
  end

  `RAU_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
  `RAU_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy)
  `RAU_ASSERT_NOW(a_err_only_zero, m_tvalid && m_tuser[0], m_tdata[64:0] == 65'd0)
  `RAU_ASSERT_NOW(a_div_nonzero, div_req.start, div_req.divisor != '0)

endmodule
